>>> sv/gf2_matrix_multiply_macros.svh
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GF2_MATRIX_MULTIPLY_MACROS_SVH
`define GF2_MATRIX_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GF2MM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gf2mm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GF2MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gf2mm assertion failed");

`endif

>>> sv/gf2mm_pkg.sv
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier package
// Shared widths, codes, configuration struct and engine state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2mm_pkg;

  localparam int ROW_W   = 64;
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int TDATA_W = 72;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 3;

  localparam int MAX_INNER_DEF = 64;
  localparam int MAX_COLS_DEF  = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic REG_INNER = 1'b0;
  localparam logic REG_COLS  = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MULT = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] inner_used;
    logic [CFG_W-1:0] cols_used;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/gf2mm_cfg_regs.sv
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier configuration registers
// APB-style register file holding the inner length and the column count.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2mm_cfg_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [gf2mm_pkg::ADDR_W-1:0]  paddr,
  input  wire [gf2mm_pkg::APB_W-1:0]   pwdata,
  output logic [gf2mm_pkg::APB_W-1:0]  prdata,
  output logic                         pready,
  output gf2mm_pkg::cfg_t              cfg
);

  gf2mm_pkg::cfg_t cfg_r;
  gf2mm_pkg::cfg_t cfg_nxt;
  logic            reg_sel;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        gf2mm_pkg::REG_INNER: cfg_nxt.inner_used = pwdata[gf2mm_pkg::CFG_W-1:0];
        gf2mm_pkg::REG_COLS:  cfg_nxt.cols_used  = pwdata[gf2mm_pkg::CFG_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inner_used <= gf2mm_pkg::CFG_RESET;
      cfg_r.cols_used  <= gf2mm_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      gf2mm_pkg::REG_INNER: prdata = gf2mm_pkg::APB_W'(cfg_r.inner_used);
      gf2mm_pkg::REG_COLS:  prdata = gf2mm_pkg::APB_W'(cfg_r.cols_used);
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/gf2mm_row_store.sv
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier row store
// Single-write, single-read memory of right-hand rows with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2mm_row_store #(
  parameter int DEPTH  = gf2mm_pkg::MAX_INNER_DEF,
  parameter int WIDTH  = gf2mm_pkg::MAX_COLS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk,
  input  wire               wr_en,
  input  wire [ADDR_W-1:0]  wr_addr,
  input  wire [WIDTH-1:0]   wr_data,
  input  wire               rd_en,
  input  wire [ADDR_W-1:0]  rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/gf2mm_engine.sv
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier row engine
// Shifts the left row out one bit per cycle, reads one stored row per cycle
// and XORs it into the accumulator when the bit is set; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2mm_engine #(
  parameter int MAX_INNER = gf2mm_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = gf2mm_pkg::MAX_COLS_DEF,
  parameter int ADDR_W    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  gf2mm_pkg::cfg_t              cfg,
  input  wire                          start,
  input  wire [MAX_INNER-1:0]          start_bits,
  input  wire [gf2mm_pkg::IDX_W-1:0]   start_idx,
  output logic                         idle,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  input  wire [MAX_COLS-1:0]           rd_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [gf2mm_pkg::ROW_W-1:0]  out_row,
  output logic [gf2mm_pkg::IDX_W-1:0]  out_index
);

  localparam int CW = gf2mm_pkg::CFG_W;
  localparam logic [CW-1:0] INNER_TOP = CW'(MAX_INNER);
  localparam logic [CW-1:0] COLS_TOP  = CW'(MAX_COLS);

  gf2mm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                 k_r;
  logic [MAX_INNER-1:0]          sel_r;
  logic [gf2mm_pkg::IDX_W-1:0]   idx_r;
  logic                          hit_r;
  logic [MAX_COLS-1:0]           acc_r;
  logic                          out_valid_r;
  logic [gf2mm_pkg::ROW_W-1:0]   out_row_r;
  logic [gf2mm_pkg::IDX_W-1:0]   out_idx_r;

  logic [CW-1:0]                 inner_eff;
  logic [CW-1:0]                 cols_eff;
  logic [CW-1:0]                 k_inc;
  logic                          last_issue;
  logic                          out_free;
  logic                          post;
  logic [MAX_COLS-1:0]           col_mask;

  assign inner_eff  = (cfg.inner_used > INNER_TOP) ? INNER_TOP : cfg.inner_used;
  assign cols_eff   = (cfg.cols_used > COLS_TOP) ? COLS_TOP : cfg.cols_used;
  assign k_inc      = CW'(k_r + 1'b1);
  assign last_issue = (k_inc == inner_eff);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (CW'(j) < cols_eff);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gf2mm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (inner_eff == '0) ? gf2mm_pkg::ST_FLUSH : gf2mm_pkg::ST_RUN;
        end
      end
      gf2mm_pkg::ST_RUN: begin
        if (last_issue) begin
          state_nxt = gf2mm_pkg::ST_FLUSH;
        end
      end
      gf2mm_pkg::ST_FLUSH: begin
        state_nxt = gf2mm_pkg::ST_DONE;
      end
      gf2mm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gf2mm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gf2mm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle  = 1'b0;
    rd_en = 1'b0;
    post  = 1'b0;
    unique case (state_r)
      gf2mm_pkg::ST_IDLE:  idle  = 1'b1;
      gf2mm_pkg::ST_RUN:   rd_en = 1'b1;
      gf2mm_pkg::ST_FLUSH: post  = 1'b0;
      gf2mm_pkg::ST_DONE:  post  = out_free;
      default:             idle  = 1'b0;
    endcase
  end

  assign rd_addr = k_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gf2mm_pkg::ST_IDLE;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= rd_en & sel_r[0];
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle && start) begin
      sel_r <= start_bits;
      idx_r <= start_idx;
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (rd_en) begin
        k_r   <= k_inc;
        sel_r <= sel_r >> 1;
      end
      if (hit_r) begin
        acc_r <= acc_r ^ rd_data;
      end
    end
    if (post) begin
      out_row_r <= gf2mm_pkg::ROW_W'(acc_r & col_mask);
      out_idx_r <= idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_index = out_idx_r;

endmodule

`default_nettype wire

>>> sv/gf2_matrix_multiply.sv
// ----------------------------------------------------------------------------
// GF(2) matrix multiplier
// Stores right-hand rows and returns one product row per left-hand row.
// ----------------------------------------------------------------------------
// Usage:
// Input transfers with in_tuser low load a right-hand row into the row store
// at row_index; indexes at or above MAX_INNER are dropped. A load produces
// no result. Input transfers with in_tuser high supply a left-hand row;
// the result leaves on the out_ channel as the XOR of the stored rows
// selected by the set bits below the inner length, masked to the column
// count. The engine reads one stored row per cycle through the row store's
// single read port, inner rows in all (inner saturated at MAX_INNER); it
// then passes a flush state and a done state, and writes the result to the
// output register in the done state once that register is free.
// in_tready is high only while the engine is idle. The output register lets
// a new item be taken while a finished result waits; when the receiver
// stalls, the next result is held in the engine until the register frees.
// Reset clears the control state and sets both configuration registers to
// 64; the row store is not cleared and each used row must be loaded first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_matrix_multiply_macros.svh"

module gf2_matrix_multiply #(
  parameter int MAX_INNER = gf2mm_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = gf2mm_pkg::MAX_COLS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata, from bit 0: row_index[5:0], row_bits[63:0], zero padding.
  input  wire [gf2mm_pkg::TDATA_W-1:0]    in_tdata,
  // in_tuser: req_type.
  input  wire                             in_tuser,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // out_tdata, from bit 0: product_row[63:0], product_index[5:0], zero padding.
  output logic [gf2mm_pkg::TDATA_W-1:0]   out_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire [gf2mm_pkg::ADDR_W-1:0]     cfg_paddr,
  input  wire [gf2mm_pkg::APB_W-1:0]      cfg_pwdata,
  output logic [gf2mm_pkg::APB_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int ADDR_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int IW     = gf2mm_pkg::IDX_W;
  localparam int RW     = gf2mm_pkg::ROW_W;

  gf2mm_pkg::cfg_t        cfg;
  logic [IW-1:0]          in_idx;
  logic [RW-1:0]          in_bits;
  logic                   in_xfer;
  logic                   eng_idle;
  logic                   wr_en;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [MAX_COLS-1:0]    rd_data;
  logic [RW-1:0]          out_row;
  logic [IW-1:0]          out_index;

  assign in_idx    = in_tdata[IW-1:0];
  assign in_bits   = in_tdata[IW+RW-1:IW];
  assign in_tready = eng_idle;
  assign in_xfer   = in_tvalid & in_tready;
  assign wr_en     = in_xfer && (in_tuser == gf2mm_pkg::REQ_LOAD) &&
                     ((IW + 1)'(in_idx) < (IW + 1)'(MAX_INNER));

  gf2mm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gf2mm_row_store #(
    .DEPTH  (MAX_INNER),
    .WIDTH  (MAX_COLS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_idx[ADDR_W-1:0]),
    .wr_data (in_bits[MAX_COLS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gf2mm_engine #(
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS),
    .ADDR_W    (ADDR_W)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (in_xfer && (in_tuser == gf2mm_pkg::REQ_MULT)),
    .start_bits (in_bits[MAX_INNER-1:0]),
    .start_idx  (in_idx),
    .idle       (eng_idle),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (out_row),
    .out_index  (out_index)
  );

  assign out_tdata = gf2mm_pkg::TDATA_W'({out_index, out_row});

  // A multiply transfer takes the engine away from idle.
  `GF2MM_ASSERT_NEXT(a_mult_busy, clk, rst_n, in_xfer && (in_tuser == gf2mm_pkg::REQ_MULT), !in_tready)
  // A new result is posted exactly as the engine returns to idle.
  `GF2MM_ASSERT_SAME(a_post_idle, clk, rst_n, $rose(out_tvalid), in_tready)
  // The row store is read only while a multiply is in progress.
  `GF2MM_ASSERT_SAME(a_read_busy, clk, rst_n, rd_en, !in_tready && !wr_en)

endmodule

`default_nettype wire
